[hdl/uvs_pkg.sv]
`default_nettype none
package uvs_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int SECTOR_FLOOR = 3;
  localparam int STACK_FLOOR = 2;
  localparam logic signed [32:0] CORDIC_X0 = 33'sh026DD3B6A;

  // register indexes on the configuration port
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SECTORS = 2'd1;
  localparam logic [1:0] REG_STACKS = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [16:0] vertex_index;
    logic [16:0] next_row_index;
    logic        upper_tri;
    logic        lower_tri;
  } uvs_side_t;

  // arctangent of 2^-k in turns, scaled by 2^32
  function automatic logic signed [31:0] atan_turn(input int k);
    logic signed [31:0] a;
    begin
      unique case (k)
        0:  a = 32'sh20000000;
        1:  a = 32'sh12E4051D;
        2:  a = 32'sh09FB385B;
        3:  a = 32'sh051111D4;
        4:  a = 32'sh028B0D43;
        5:  a = 32'sh0145D7E1;
        6:  a = 32'sh00A2F61E;
        7:  a = 32'sh00517C55;
        8:  a = 32'sh0028BE53;
        9:  a = 32'sh00145F2E;
        10: a = 32'sh000A2F98;
        11: a = 32'sh000517CC;
        12: a = 32'sh00028BE6;
        13: a = 32'sh000145F3;
        14: a = 32'sh0000A2F9;
        15: a = 32'sh0000517C;
        16: a = 32'sh000028BE;
        17: a = 32'sh0000145F;
        18: a = 32'sh00000A2F;
        19: a = 32'sh00000517;
        20: a = 32'sh0000028B;
        21: a = 32'sh00000145;
        22: a = 32'sh000000A2;
        23: a = 32'sh00000051;
        default: a = 32'sh00000000;
      endcase
      return a;
    end
  endfunction

endpackage
`default_nettype wire

[hdl/uv_sphere_vertex_generator_unit.sv]
`default_nettype none
// UV sphere vertex generator.
// Drive stack_index and sector_index with start high; a beat is taken at
// every clock edge with start high and busy low. busy stays low, so one
// grid point enters per cycle, back to back.
// Each beat returns one result beat: position, normal, mesh index, the index
// of the point one row below and the two triangle flags, shown with done high
// for exactly one cycle. On its way the beat passes through the pipelined
// restoring dividers that form the sector and stack angles (ANGLE_BITS + 11
// cells), the 24 CORDIC cells, and the rounding, two multiplier and output
// stages behind them.
// The receiver cannot stall: results leave in order, one per accepted beat.
// Configuration: cfg_we with cfg_index 0 (radius), 1 (sector count) or
// 2 (stack count) writes cfg_data at once; write only while no beat is in
// flight. A zero radius is dropped, counts are clamped to their legal range.
// Reset (rst, synchronous) empties the pipeline and restores radius 1.0,
// 36 sectors and 18 stacks.
module uv_sphere_vertex_generator_unit
  import uvs_pkg::*;
#(
  parameter int MAX_SECTORS = 256,
  parameter int MAX_STACKS = 256,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [8:0]         stack_index,
  input  wire logic [8:0]         sector_index,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    done,
  output logic signed [15:0]      pos_x,
  output logic signed [15:0]      pos_y,
  output logic signed [15:0]      pos_z,
  output logic signed [15:0]      norm_x,
  output logic signed [15:0]      norm_y,
  output logic signed [15:0]      norm_z,
  output logic [16:0]             vertex_index,
  output logic [16:0]             next_row_index,
  output logic                    upper_tri_valid,
  output logic                    lower_tri_valid
);

  localparam int A = ANGLE_BITS;
  localparam int NW = A + 11;              // dividend and quotient width
  localparam int DW = 10;                  // twice a 9-bit count
  localparam int CS = CORDIC_STEPS;
  localparam int LEN = NW + CS + 3;        // sideband delay to the output stage

  // configuration registers
  logic [15:0] radius;
  logic [8:0]  sector_count;
  logic [8:0]  stack_count;
  logic [8:0]  cnt_next;

  always_comb begin
    cnt_next = cfg_data[8:0];
    if (cfg_index == REG_SECTORS) begin
      if (32'(cnt_next) < SECTOR_FLOOR) cnt_next = 9'(SECTOR_FLOOR);
      if (32'(cnt_next) > MAX_SECTORS) cnt_next = 9'(MAX_SECTORS);
    end else begin
      if (32'(cnt_next) < STACK_FLOOR) cnt_next = 9'(STACK_FLOOR);
      if (32'(cnt_next) > MAX_STACKS) cnt_next = 9'(MAX_STACKS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd256;
      sector_count <= 9'd36;
      stack_count <= 9'd18;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS:  if (cfg_data != 16'd0) radius <= cfg_data;
        REG_SECTORS: sector_count <= cnt_next;
        REG_STACKS:  stack_count <= cnt_next;
        default: ;   // drop writes past the register list
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage: hold the accepted beat
  logic       in_valid;
  logic [8:0] i_q;
  logic [8:0] j_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    i_q <= stack_index;
    j_q <= sector_index;
  end

  // mesh indexes and triangle flags, computed once and delayed
  uvs_side_t   side_head;
  uvs_side_t   side [1:LEN];
  logic [18:0] vprod;
  logic [16:0] vidx;
  logic        is_cell;

  always_comb begin
    vprod = 19'(i_q) * (19'(sector_count) + 19'd1) + 19'(j_q);
    vidx = vprod[16:0];
    is_cell = (i_q < stack_count) && (j_q < sector_count);
    side_head.valid = in_valid;
    side_head.vertex_index = vidx;
    side_head.next_row_index = is_cell ? (vidx + 17'(sector_count) + 17'd1) : 17'd0;
    side_head.upper_tri = is_cell && (i_q != 9'd0);
    side_head.lower_tri = is_cell && (i_q != stack_count - 9'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side[1].valid <= 1'b0;
    end else begin
      side[1].valid <= side_head.valid;
    end
    side[1].vertex_index <= side_head.vertex_index;
    side[1].next_row_index <= side_head.next_row_index;
    side[1].upper_tri <= side_head.upper_tri;
    side[1].lower_tri <= side_head.lower_tri;
    for (int k = 1; k < LEN; k++) begin
      if (rst) begin
        side[k+1].valid <= 1'b0;
      end else begin
        side[k+1].valid <= side[k].valid;
      end
      side[k+1].vertex_index <= side[k].vertex_index;
      side[k+1].next_row_index <= side[k].next_row_index;
      side[k+1].upper_tri <= side[k].upper_tri;
      side[k+1].lower_tri <= side[k].lower_tri;
    end
  end

  // angle dividers: sector angle and stack offset, one quotient bit per cell
  logic [DW-1:0] prem [0:NW];
  logic [NW-1:0] pq   [0:NW];
  logic [DW-1:0] trem [0:NW];
  logic [NW-1:0] tq   [0:NW];

  assign prem[0] = '0;
  assign trem[0] = '0;
  assign pq[0] = {1'b0, j_q, {(A+1){1'b0}}} + NW'(sector_count);
  assign tq[0] = {2'b00, i_q, {A{1'b0}}} + NW'(stack_count);

  for (genvar k = 0; k < NW; k++) begin : g_div
    uvs_div_cell #(.DW(DW), .NW(NW)) u_phi (
      .clk(clk), .divisor({sector_count, 1'b0}),
      .rem_in(prem[k]), .q_in(pq[k]), .rem_out(prem[k+1]), .q_out(pq[k+1])
    );
    uvs_div_cell #(.DW(DW), .NW(NW)) u_theta (
      .clk(clk), .divisor({stack_count, 1'b0}),
      .rem_in(trem[k]), .q_in(tq[k]), .rem_out(trem[k+1]), .q_out(tq[k+1])
    );
  end

  // turn fractions into quadrant and first-quadrant CORDIC angle
  logic [A-1:0] phi;
  logic [A-1:0] theta;

  assign phi = pq[NW][A-1:0];
  assign theta = A'(1 << (A - 2)) - tq[NW][A-1:0];

  logic signed [32:0] px [0:CS];
  logic signed [32:0] py [0:CS];
  logic signed [31:0] pz [0:CS];
  logic        [1:0]  pqd [0:CS];
  logic signed [32:0] tx [0:CS];
  logic signed [32:0] ty [0:CS];
  logic signed [31:0] tz [0:CS];
  logic        [1:0]  tqd [0:CS];

  assign px[0] = CORDIC_X0;
  assign py[0] = '0;
  assign pz[0] = {2'b00, phi[A-3:0], {(32-A){1'b0}}};
  assign pqd[0] = phi[A-1:A-2];
  assign tx[0] = CORDIC_X0;
  assign ty[0] = '0;
  assign tz[0] = {2'b00, theta[A-3:0], {(32-A){1'b0}}};
  assign tqd[0] = theta[A-1:A-2];

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    uvs_cordic_cell #(.STEP(k)) u_phi (
      .clk(clk), .x_in(px[k]), .y_in(py[k]), .z_in(pz[k]), .quad_in(pqd[k]),
      .x_out(px[k+1]), .y_out(py[k+1]), .z_out(pz[k+1]), .quad_out(pqd[k+1])
    );
    uvs_cordic_cell #(.STEP(k)) u_theta (
      .clk(clk), .x_in(tx[k]), .y_in(ty[k]), .z_in(tz[k]), .quad_in(tqd[k]),
      .x_out(tx[k+1]), .y_out(ty[k+1]), .z_out(tz[k+1]), .quad_out(tqd[k+1])
    );
  end

  // round half up to Q1.14 and saturate to plus or minus one
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = (v + 34'sd32768) >>> 16;
      if (r > 34'sd16384) return 16'sd16384;
      if (r < -34'sd16384) return -16'sd16384;
      return r[15:0];
    end
  endfunction

  function automatic logic signed [33:0] pick_cos(input logic [1:0] q,
      input logic signed [32:0] x, input logic signed [32:0] y);
    logic signed [33:0] xe;
    logic signed [33:0] ye;
    begin
      xe = 34'(x);
      ye = 34'(y);
      unique case (q)
        2'd0: return xe;
        2'd1: return -ye;
        2'd2: return -xe;
        default: return ye;
      endcase
    end
  endfunction

  function automatic logic signed [33:0] pick_sin(input logic [1:0] q,
      input logic signed [32:0] x, input logic signed [32:0] y);
    logic signed [33:0] xe;
    logic signed [33:0] ye;
    begin
      xe = 34'(x);
      ye = 34'(y);
      unique case (q)
        2'd0: return ye;
        2'd1: return xe;
        2'd2: return -ye;
        default: return -xe;
      endcase
    end
  endfunction

  // quadrant fold and rounding
  logic signed [15:0] ct, st, cp, sp;

  always_ff @(posedge clk) begin
    ct <= to_q14(pick_cos(tqd[CS], tx[CS], ty[CS]));
    st <= to_q14(pick_sin(tqd[CS], tx[CS], ty[CS]));
    cp <= to_q14(pick_cos(pqd[CS], px[CS], py[CS]));
    sp <= to_q14(pick_sin(pqd[CS], px[CS], py[CS]));
  end

  // first multiplier stage: direction products
  logic signed [31:0] pxy_x, pxy_y;
  logic signed [15:0] st_d;

  always_ff @(posedge clk) begin
    pxy_x <= ct * cp;
    pxy_y <= ct * sp;
    st_d <= st;
  end

  // second multiplier stage: scale by radius, round the normals
  logic signed [16:0] r_s;
  logic signed [48:0] rx, ry;
  logic signed [32:0] rz;
  logic signed [15:0] nx, ny, nz;
  logic signed [31:0] nxr, nyr;

  assign r_s = {1'b0, radius};

  always_comb begin
    nxr = (pxy_x + 32'sd8192) >>> 14;
    nyr = (pxy_y + 32'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    rx <= r_s * pxy_x;
    ry <= r_s * pxy_y;
    rz <= r_s * st_d;
    nx <= (nxr > 32'sd16384) ? 16'sd16384 :
          (nxr < -32'sd16384) ? -16'sd16384 : nxr[15:0];
    ny <= (nyr > 32'sd16384) ? 16'sd16384 :
          (nyr < -32'sd16384) ? -16'sd16384 : nyr[15:0];
    nz <= st_d;
  end

  // output stage: round and saturate positions, attach indexes
  logic signed [48:0] rxr, ryr;
  logic signed [32:0] rzr;

  always_comb begin
    rxr = (rx + 49'sd134217728) >>> 28;
    ryr = (ry + 49'sd134217728) >>> 28;
    rzr = (rz + 33'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side[LEN].valid;
    end
    pos_x <= (rxr > 49'sd32767) ? 16'sh7FFF :
             (rxr < -49'sd32768) ? 16'sh8000 : rxr[15:0];
    pos_y <= (ryr > 49'sd32767) ? 16'sh7FFF :
             (ryr < -49'sd32768) ? 16'sh8000 : ryr[15:0];
    pos_z <= (rzr > 33'sd32767) ? 16'sh7FFF :
             (rzr < -33'sd32768) ? 16'sh8000 : rzr[15:0];
    norm_x <= nx;
    norm_y <= ny;
    norm_z <= nz;
    vertex_index <= side[LEN].vertex_index;
    next_row_index <= side[LEN].next_row_index;
    upper_tri_valid <= side[LEN].upper_tri;
    lower_tri_valid <= side[LEN].lower_tri;
  end

endmodule
`default_nettype wire

[hdl/uvs_div_cell.sv]
`default_nettype none
// One restoring division step: shift in a dividend bit, subtract if it fits.
module uvs_div_cell
  import uvs_pkg::*;
#(
  parameter int DW = 10,
  parameter int NW = 27
) (
  input  wire logic          clk,
  input  wire logic [DW-1:0] divisor,
  input  wire logic [DW-1:0] rem_in,
  input  wire logic [NW-1:0] q_in,
  output logic      [DW-1:0] rem_out,
  output logic      [NW-1:0] q_out
);

  logic [DW:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem_in, q_in[NW-1]};
    fits = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (fits) begin
      rem_out <= DW'(trial - {1'b0, divisor});
    end else begin
      rem_out <= trial[DW-1:0];
    end
    q_out <= {q_in[NW-2:0], fits};
  end

endmodule
`default_nettype wire

[hdl/uvs_cordic_cell.sv]
`default_nettype none
// One rotation-mode CORDIC micro-rotation; the quadrant rides along.
module uvs_cordic_cell
  import uvs_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic               clk,
  input  wire logic signed [32:0] x_in,
  input  wire logic signed [32:0] y_in,
  input  wire logic signed [31:0] z_in,
  input  wire logic        [1:0]  quad_in,
  output logic signed      [32:0] x_out,
  output logic signed      [32:0] y_out,
  output logic signed      [31:0] z_out,
  output logic             [1:0]  quad_out
);

  localparam logic signed [31:0] ATAN = atan_turn(STEP);

  logic signed [32:0] dx;
  logic signed [32:0] dy;

  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
  end

  always_ff @(posedge clk) begin
    if (!z_in[31]) begin
      x_out <= x_in - dx;
      y_out <= y_in + dy;
      z_out <= z_in - ATAN;
    end else begin
      x_out <= x_in + dx;
      y_out <= y_in - dy;
      z_out <= z_in + ATAN;
    end
    quad_out <= quad_in;
  end

endmodule
`default_nettype wire

[verif/testbench.sv]
module testbench;
  import uvs_pkg::*;

  typedef struct {
    logic [8:0] stack_i;
    logic [8:0] sector_j;
    int         gap;
  } grid_point_t;

  typedef struct {
    logic signed [15:0] pos_x, pos_y, pos_z;
    logic signed [15:0] norm_x, norm_y, norm_z;
    logic [16:0]        vertex_index, next_row_index;
    logic               upper_tri, lower_tri;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [8:0] stack_index = '0;
  logic [8:0] sector_index = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic busy, done;
  logic signed [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
  logic [16:0] vertex_index, next_row_index;
  logic upper_tri_valid, lower_tri_valid;

  // shadow copy of the configuration, always post-clamp
  longint radius_q = 256;
  longint sectors_q = 36;
  longint stacks_q = 18;

  grid_point_t pending_points[$];
  vertex_t     expected_vertices[$];
  int          mismatch_count = 0;
  int          gap_left = 0;
  bit          burst_mode = 1'b0;

  uv_sphere_vertex_generator_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .stack_index(stack_index), .sector_index(sector_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .vertex_index(vertex_index), .next_row_index(next_row_index),
    .upper_tri_valid(upper_tri_valid), .lower_tri_valid(lower_tri_valid)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the pipeline never drains.
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round half up: arithmetic shift on longint floors
  function automatic longint round_down_by(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Rotation-mode CORDIC on a 16-bit turn fraction; Q1.14 cos/sin out.
  function automatic void turn_sincos(input logic [15:0] angle,
                                      output longint c_q14, output longint s_q14);
    logic [31:0] a32;
    longint x, y, z, dx, dy, c, s;
    a32 = {angle, 16'h0000};
    x = CORDIC_X0;
    y = 0;
    z = longint'(a32[29:0]);
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(k));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(k));
      end
    end
    case (a32[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c_q14 = clip(round_down_by(c, 16), -16384, 16384);
    s_q14 = clip(round_down_by(s, 16), -16384, 16384);
  endfunction

  function automatic vertex_t sphere_vertex(logic [8:0] si, logic [8:0] sj);
    vertex_t v;
    longint i, j, phi, off, theta, ct, st, cp, sp, vidx;
    bit on_grid;
    i = longint'(si);
    j = longint'(sj);
    phi = ((j << 17) + sectors_q) / (2 * sectors_q);
    off = ((i << 16) + stacks_q) / (2 * stacks_q);
    theta = (16384 - off) & 64'hFFFF;
    turn_sincos(theta[15:0], ct, st);
    turn_sincos(phi[15:0], cp, sp);
    v.pos_x = 16'(clip(round_down_by(radius_q * ct * cp, 28), -32768, 32767));
    v.pos_y = 16'(clip(round_down_by(radius_q * ct * sp, 28), -32768, 32767));
    v.pos_z = 16'(clip(round_down_by(radius_q * st, 14), -32768, 32767));
    v.norm_x = 16'(clip(round_down_by(ct * cp, 14), -16384, 16384));
    v.norm_y = 16'(clip(round_down_by(ct * sp, 14), -16384, 16384));
    v.norm_z = 16'(st);
    on_grid = (i < stacks_q) && (j < sectors_q);
    vidx = (i * (sectors_q + 1) + j) & 64'h1FFFF;
    v.vertex_index = 17'(vidx);
    v.next_row_index = on_grid ? 17'((vidx + sectors_q + 1) & 64'h1FFFF) : 17'd0;
    v.upper_tri = on_grid && (i != 0);
    v.lower_tri = on_grid && (i != stacks_q - 1);
    return v;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  // Driver: hold the beat until accepted, then wait the drawn gap.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_vertices = {expected_vertices, sphere_vertex(stack_index, sector_index)};
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_points.size() > 0) begin
        stack_index <= pending_points[0].stack_i;
        sector_index <= pending_points[0].sector_j;
        gap_left <= pending_points[0].gap;
        start <= 1'b1;
        void'(pending_points.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done beat must match the oldest prediction.
  always @(posedge clk) begin
    vertex_t w;
    if (!rst && done) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        w = expected_vertices.pop_front();
        if (pos_x !== w.pos_x) report_mismatch("pos_x", pos_x, w.pos_x);
        if (pos_y !== w.pos_y) report_mismatch("pos_y", pos_y, w.pos_y);
        if (pos_z !== w.pos_z) report_mismatch("pos_z", pos_z, w.pos_z);
        if (norm_x !== w.norm_x) report_mismatch("norm_x", norm_x, w.norm_x);
        if (norm_y !== w.norm_y) report_mismatch("norm_y", norm_y, w.norm_y);
        if (norm_z !== w.norm_z) report_mismatch("norm_z", norm_z, w.norm_z);
        if (vertex_index !== w.vertex_index)
          report_mismatch("vertex_index", vertex_index, w.vertex_index);
        if (next_row_index !== w.next_row_index)
          report_mismatch("next_row_index", next_row_index, w.next_row_index);
        if (upper_tri_valid !== w.upper_tri)
          report_mismatch("upper_tri_valid", upper_tri_valid, w.upper_tri);
        if (lower_tri_valid !== w.lower_tri)
          report_mismatch("lower_tri_valid", lower_tri_valid, w.lower_tri);
      end
    end
  end

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void queue_point(int si, int sj);
    grid_point_t p;
    p.stack_i = 9'(si);
    p.sector_j = 9'(sj);
    p.gap = draw_gap();
    pending_points = {pending_points, p};
  endfunction

  // Mostly points on the grid (and one past it), some anywhere in the field.
  function automatic void queue_random_points(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 85)
        queue_point($urandom_range(0, stacks_q), $urandom_range(0, sectors_q));
      else
        queue_point($urandom_range(0, 511), $urandom_range(0, 511));
    end
  endfunction

  // Write one register and mirror the clamping in the shadow copy.
  task automatic write_reg(logic [1:0] idx, int value);
    logic [15:0] d;
    longint v;
    d = 16'($urandom);
    if (idx == REG_RADIUS) d = 16'(value);
    else d[8:0] = 9'(value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RADIUS) begin
      if (d != 0) radius_q = d;
    end else if (idx == REG_SECTORS) begin
      v = d[8:0];
      sectors_q = clip(v, SECTOR_FLOOR, 256);
    end else if (idx == REG_STACKS) begin
      v = d[8:0];
      stacks_q = clip(v, STACK_FLOOR, 256);
    end
  endtask

  // Drain: every beat out, every prediction met, then the pipeline depth.
  task automatic wait_drained();
    while (pending_points.size() != 0 || start || expected_vertices.size() != 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the reset configuration: poles, seam, corners,
    // points past the grid and all-ones fields.
    queue_point(0, 0);   queue_point(0, 36);  queue_point(18, 0);
    queue_point(18, 36); queue_point(17, 35); queue_point(1, 1);
    queue_point(9, 18);  queue_point(17, 0);  queue_point(0, 35);
    queue_point(511, 511); queue_point(256, 256); queue_point(37, 100);
    queue_point(19, 37); queue_point(4, 9);   queue_point(13, 27);
    queue_random_points(135);

    for (int phase = 1; phase <= 8; phase++) begin
      wait_drained();
      case (phase)
        1: begin write_reg(REG_RADIUS, 1); write_reg(REG_SECTORS, 3);
                 write_reg(REG_STACKS, 2); end
        2: begin write_reg(REG_RADIUS, 65535); write_reg(REG_SECTORS, 256);
                 write_reg(REG_STACKS, 256); end
        3: begin
          // zero radius and the unused index must leave everything alone
          write_reg(REG_RADIUS, 0); write_reg(2'd3, $urandom_range(0, 65535));
          write_reg(REG_SECTORS, 0); write_reg(REG_STACKS, 1);
        end
        4: begin write_reg(REG_RADIUS, 16'h1234); write_reg(REG_SECTORS, 511);
                 write_reg(REG_STACKS, 5); end
        5: begin write_reg(REG_SECTORS, 2); write_reg(REG_STACKS, 300); end
        default: begin
          write_reg(REG_RADIUS, $urandom_range(1, 65535));
          write_reg(REG_SECTORS, $urandom_range(3, 256));
          write_reg(REG_STACKS, $urandom_range(2, 256));
        end
      endcase
      burst_mode = (phase % 3 == 0);
      queue_point(0, 0);
      queue_point(stacks_q, sectors_q);
      queue_point(stacks_q - 1, sectors_q - 1);
      queue_random_points(72);
      if (phase == 2) begin
        // pause the sender until the pipeline is empty
        wait_drained();
        burst_mode = 1'b0;
      end
      queue_random_points(73);
    end

    wait_drained();
    if (mismatch_count == 0 && expected_vertices.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
